@@ hw/rtl/line_rasterizer_top_defines.svh @@
// Assertion macros shared by the line rasteriser checker.
// Depends on nothing; included by the checker file.
`ifndef LINE_RASTERIZER_TOP_DEFINES_SVH
`define LINE_RASTERIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define LR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define LR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/lr_pkg.sv @@
// Shared types and constants of the line rasteriser.
// Depends on nothing; imported by every RTL module of the block.
package lr_pkg;

   localparam int LR_COORD_BITS = 12;
   localparam int DIM_BITS      = 11;
   localparam int FQ_DEPTH      = 2;
   localparam int RQ_DEPTH      = 2;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MAP_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAP_HEIGHT = 1'd1;

   localparam logic [DIM_BITS-1:0] MAP_WIDTH_RESET  = 11'd640;
   localparam logic [DIM_BITS-1:0] MAP_HEIGHT_RESET = 11'd640;

   typedef struct packed {
      logic op;
      logic steep;
      logic minor_down;
   } lr_cmd_type;

   typedef struct packed {
      logic inside_res;
      logic last;
   } lr_flags_type;

endpackage

@@ hw/rtl/lr_front.sv @@
// Front end: classifies incoming items (axis, direction, ordering) and queues them.
// Depends on lr_pkg.
module lr_front import lr_pkg::*; #(
   parameter int COORD_BITS = LR_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_op,
   input  logic signed [COORD_BITS-1:0] req_x_start,
   input  logic signed [COORD_BITS-1:0] req_y_start,
   input  logic signed [COORD_BITS-1:0] req_x_end,
   input  logic signed [COORD_BITS-1:0] req_y_end,
   output logic                         head_valid,
   input  logic                         head_pop,
   output lr_cmd_type                   head_cmd,
   output logic signed [COORD_BITS-1:0] head_start_major,
   output logic signed [COORD_BITS-1:0] head_start_minor,
   output logic signed [COORD_BITS-1:0] head_end_major,
   output logic        [COORD_BITS-1:0] head_dmaj,
   output logic        [COORD_BITS-1:0] head_dmin
);

   localparam int PTR_BITS = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(FQ_DEPTH + 1);

   logic signed [COORD_BITS:0]   dx, dy, d_minor, neg_dx, neg_dy;
   logic        [COORD_BITS-1:0] adx, ady;
   logic                         steep, swap;
   lr_cmd_type                   cmd;
   logic signed [COORD_BITS-1:0] s_major, s_minor, e_major;
   logic        [COORD_BITS-1:0] dmaj, dmin;
   logic                         do_push;

   lr_cmd_type                   cmd_mem_ff   [FQ_DEPTH];
   logic signed [COORD_BITS-1:0] smaj_mem_ff  [FQ_DEPTH];
   logic signed [COORD_BITS-1:0] smin_mem_ff  [FQ_DEPTH];
   logic signed [COORD_BITS-1:0] emaj_mem_ff  [FQ_DEPTH];
   logic        [COORD_BITS-1:0] dmaj_mem_ff  [FQ_DEPTH];
   logic        [COORD_BITS-1:0] dmin_mem_ff  [FQ_DEPTH];
   logic [PTR_BITS-1:0]          wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;

   // classify: axis, ordering along the major axis, minor direction
   always_comb begin
      dx     = {req_x_end[COORD_BITS-1], req_x_end} - {req_x_start[COORD_BITS-1], req_x_start};
      dy     = {req_y_end[COORD_BITS-1], req_y_end} - {req_y_start[COORD_BITS-1], req_y_start};
      neg_dx = -dx;
      neg_dy = -dy;
      adx    = dx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
      ady    = dy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
      steep  = ady > adx;
      swap   = steep ? dy[COORD_BITS] : dx[COORD_BITS];
      d_minor = steep ? dx : dy;
      if (steep) begin
         s_major = swap ? req_y_end   : req_y_start;
         s_minor = swap ? req_x_end   : req_x_start;
         e_major = swap ? req_y_start : req_y_end;
         dmaj    = ady;
         dmin    = adx;
      end else begin
         s_major = swap ? req_x_end   : req_x_start;
         s_minor = swap ? req_y_end   : req_y_start;
         e_major = swap ? req_x_start : req_x_end;
         dmaj    = adx;
         dmin    = ady;
      end
      cmd.op         = req_op;
      cmd.steep      = steep;
      cmd.minor_down = (d_minor != '0) && (d_minor[COORD_BITS] ^ swap);
   end

   assign req_full = (count_ff == CNT_BITS'(FQ_DEPTH));
   assign do_push  = req_push && !req_full;

   assign head_valid       = (count_ff != '0);
   assign head_cmd         = cmd_mem_ff[rd_ptr_ff];
   assign head_start_major = smaj_mem_ff[rd_ptr_ff];
   assign head_start_minor = smin_mem_ff[rd_ptr_ff];
   assign head_end_major   = emaj_mem_ff[rd_ptr_ff];
   assign head_dmaj        = dmaj_mem_ff[rd_ptr_ff];
   assign head_dmin        = dmin_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = head_pop ? PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         cmd_mem_ff[wr_ptr_ff]  <= cmd;
         smaj_mem_ff[wr_ptr_ff] <= s_major;
         smin_mem_ff[wr_ptr_ff] <= s_minor;
         emaj_mem_ff[wr_ptr_ff] <= e_major;
         dmaj_mem_ff[wr_ptr_ff] <= dmaj;
         dmin_mem_ff[wr_ptr_ff] <= dmin;
      end
   end

endmodule

@@ hw/rtl/lr_back.sv @@
// Back end: clipping Bresenham engine; a pixel per cycle unless stalled.
// Depends on lr_pkg.
module lr_back import lr_pkg::*; #(
   parameter int COORD_BITS = LR_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   output logic                         head_pop,
   input  lr_cmd_type                   head_cmd,
   input  logic signed [COORD_BITS-1:0] head_start_major,
   input  logic signed [COORD_BITS-1:0] head_start_minor,
   input  logic signed [COORD_BITS-1:0] head_end_major,
   input  logic        [COORD_BITS-1:0] head_dmaj,
   input  logic        [COORD_BITS-1:0] head_dmin,
   input  logic        [DIM_BITS-1:0]   map_width,
   input  logic        [DIM_BITS-1:0]   map_height,
   input  logic                         out_space,
   output logic                         out_push,
   output logic signed [COORD_BITS-1:0] out_pixel_x,
   output logic signed [COORD_BITS-1:0] out_pixel_y,
   output lr_flags_type                 out_flags
);

   localparam int DW       = COORD_BITS + 2;
   localparam int CMP_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

   logic                         busy_ff, steep_ff, minor_down_ff;
   logic signed [COORD_BITS-1:0] cur_major_ff, cur_minor_ff, end_major_ff;
   logic signed [DW-1:0]         decision_ff, inc_diagonal_ff;
   logic        [COORD_BITS:0]   inc_straight_ff;

   logic                         is_load, tick_emit, load_take, fin, step;
   logic signed [DW-1:0]         two_dmin, two_dmaj, one_dmaj;

   assign is_load   = (head_cmd.op == OP_LOAD);
   assign tick_emit = head_valid && !is_load && busy_ff;
   assign load_take = head_valid && is_load && !busy_ff;
   assign head_pop  = head_valid && (!tick_emit || out_space);
   assign out_push  = tick_emit && out_space;
   assign fin       = (cur_major_ff >= end_major_ff);
   assign step      = out_push && !fin;

   assign two_dmin = $signed({1'b0, head_dmin, 1'b0});
   assign two_dmaj = $signed({1'b0, head_dmaj, 1'b0});
   assign one_dmaj = $signed({2'b00, head_dmaj});

   always_comb begin
      out_pixel_x          = steep_ff ? cur_minor_ff : cur_major_ff;
      out_pixel_y          = steep_ff ? cur_major_ff : cur_minor_ff;
      out_flags.last       = fin;
      out_flags.inside_res = !out_pixel_x[COORD_BITS-1] && !out_pixel_y[COORD_BITS-1]
         && (CMP_BITS'($unsigned(out_pixel_x)) < CMP_BITS'(map_width))
         && (CMP_BITS'($unsigned(out_pixel_y)) < CMP_BITS'(map_height));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load_take) begin
         busy_ff <= 1'b1;
      end else if (out_push && fin) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_take) begin
         steep_ff        <= head_cmd.steep;
         minor_down_ff   <= head_cmd.minor_down;
         cur_major_ff    <= head_start_major;
         cur_minor_ff    <= head_start_minor;
         end_major_ff    <= head_end_major;
         inc_straight_ff <= {head_dmin, 1'b0};
         inc_diagonal_ff <= two_dmin - two_dmaj;
         decision_ff     <= two_dmin - one_dmaj;
      end else if (step) begin
         cur_major_ff <= cur_major_ff + 1'b1;
         if (decision_ff[DW-1] || (decision_ff == '0)) begin
            decision_ff <= decision_ff + $signed({1'b0, inc_straight_ff});
         end else begin
            decision_ff  <= decision_ff + inc_diagonal_ff;
            cur_minor_ff <= minor_down_ff ? cur_minor_ff - 1'b1 : cur_minor_ff + 1'b1;
         end
      end
   end

endmodule

@@ hw/rtl/lr_rsp_queue.sv @@
// Result queue holding finished pixels until the consumer pops them.
// Depends on lr_pkg.
module lr_rsp_queue import lr_pkg::*; #(
   parameter int COORD_BITS = LR_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   output logic                         wr_space,
   input  logic signed [COORD_BITS-1:0] wr_pixel_x,
   input  logic signed [COORD_BITS-1:0] wr_pixel_y,
   input  lr_flags_type                 wr_flags,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_inside_res,
   output logic                         rsp_last
);

   localparam int PTR_BITS = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(RQ_DEPTH + 1);

   logic signed [COORD_BITS-1:0] px_mem_ff [RQ_DEPTH];
   logic signed [COORD_BITS-1:0] py_mem_ff [RQ_DEPTH];
   lr_flags_type                 fl_mem_ff [RQ_DEPTH];
   logic [PTR_BITS-1:0]          wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic                         do_pop;

   assign rsp_empty      = (count_ff == '0);
   assign do_pop         = rsp_pop && !rsp_empty;
   assign wr_space       = (count_ff != CNT_BITS'(RQ_DEPTH)) || do_pop;
   assign rsp_pixel_x    = px_mem_ff[rd_ptr_ff];
   assign rsp_pixel_y    = py_mem_ff[rd_ptr_ff];
   assign rsp_inside_res = fl_mem_ff[rd_ptr_ff].inside_res;
   assign rsp_last       = fl_mem_ff[rd_ptr_ff].last;

   always_comb begin
      wr_ptr_in = wr_en ? PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         px_mem_ff[wr_ptr_ff] <= wr_pixel_x;
         py_mem_ff[wr_ptr_ff] <= wr_pixel_y;
         fl_mem_ff[wr_ptr_ff] <= wr_flags;
      end
   end

endmodule

@@ hw/rtl/line_rasterizer_top.sv @@
// Line rasteriser top level: Bresenham pixel generator with map clipping.
// A tick's pixel passes the front queue, then the result queue, before it shows on rsp_.
// Throughput: one item per cycle unless results back up, set by one add-and-compare step.
// Reset (synchronous, active high): both queues empty, engine idle, map size 640 x 640.
// Depends on lr_pkg, lr_front, lr_back and lr_rsp_queue.
module line_rasterizer_top import lr_pkg::*; #(
   parameter int COORD_BITS = LR_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel: a transfer happens when req_push is high and req_full low
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_op,
   input  logic signed [COORD_BITS-1:0] req_x_start,
   input  logic signed [COORD_BITS-1:0] req_y_start,
   input  logic signed [COORD_BITS-1:0] req_x_end,
   input  logic signed [COORD_BITS-1:0] req_y_end,
   // result channel: oldest pixel shown while rsp_empty is low
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_inside_res,
   output logic                         rsp_last,
   // register write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [DIM_BITS-1:0]          csr_data
);

   logic                         head_valid, head_pop;
   lr_cmd_type                   head_cmd;
   logic signed [COORD_BITS-1:0] head_start_major, head_start_minor, head_end_major;
   logic        [COORD_BITS-1:0] head_dmaj, head_dmin;
   logic                         out_space, out_push;
   logic signed [COORD_BITS-1:0] out_pixel_x, out_pixel_y;
   lr_flags_type                 out_flags;
   logic [DIM_BITS-1:0]          map_width_ff, map_height_ff;

   // Register writes always taken; the user must send them only while idle (unchecked).
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= MAP_WIDTH_RESET;
         map_height_ff <= MAP_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAP_WIDTH:  map_width_ff  <= csr_data;
            CSR_MAP_HEIGHT: map_height_ff <= csr_data;
            default: begin
               // hold both registers on an unknown index
            end
         endcase
      end
   end

   // Front: work out axis, direction and endpoint order, then queue the item.
   lr_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_op           (req_op),
      .req_x_start      (req_x_start),
      .req_y_start      (req_y_start),
      .req_x_end        (req_x_end),
      .req_y_end        (req_y_end),
      .head_valid       (head_valid),
      .head_pop         (head_pop),
      .head_cmd         (head_cmd),
      .head_start_major (head_start_major),
      .head_start_minor (head_start_minor),
      .head_end_major   (head_end_major),
      .head_dmaj        (head_dmaj),
      .head_dmin        (head_dmin)
   );

   // Back: load a line or step one pixel per cycle while results have room; drop ticks
   // while idle and loads while a line is in progress.
   lr_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_pop         (head_pop),
      .head_cmd         (head_cmd),
      .head_start_major (head_start_major),
      .head_start_minor (head_start_minor),
      .head_end_major   (head_end_major),
      .head_dmaj        (head_dmaj),
      .head_dmin        (head_dmin),
      .map_width        (map_width_ff),
      .map_height       (map_height_ff),
      .out_space        (out_space),
      .out_push         (out_push),
      .out_pixel_x      (out_pixel_x),
      .out_pixel_y      (out_pixel_y),
      .out_flags        (out_flags)
   );

   // Result queue: lets the engine advance while earlier pixels await transfer.
   lr_rsp_queue #(.COORD_BITS(COORD_BITS)) u_rsp_queue (
      .clock          (clock),
      .reset          (reset),
      .wr_en          (out_push),
      .wr_space       (out_space),
      .wr_pixel_x     (out_pixel_x),
      .wr_pixel_y     (out_pixel_y),
      .wr_flags       (out_flags),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_inside_res (rsp_inside_res),
      .rsp_last       (rsp_last)
   );

endmodule

@@ hw/rtl/lr_checker.sv @@
// Port-level checker for the line rasteriser, bound to the top level.
// Depends on lr_pkg and line_rasterizer_top_defines.svh.
`include "line_rasterizer_top_defines.svh"

module lr_checker import lr_pkg::*; #(
   parameter int COORD_BITS = LR_COORD_BITS
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_full,
   input logic                         rsp_empty,
   input logic                         rsp_pop,
   input logic signed [COORD_BITS-1:0] rsp_pixel_x,
   input logic signed [COORD_BITS-1:0] rsp_pixel_y,
   input logic                         rsp_inside_res,
   input logic                         csr_valid,
   input logic                         csr_ready
);

   `LR_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, rsp_empty && !req_full, "queues not empty after reset")
   `LR_ASSERT_NEXT(a_rsp_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_pixel_x) && $stable(rsp_pixel_y), "waiting pixel changed")
   `LR_ASSERT_NOW(a_inside_sign, clock, reset, !rsp_empty && rsp_inside_res, !rsp_pixel_x[COORD_BITS-1] && !rsp_pixel_y[COORD_BITS-1], "negative pixel flagged inside")
   `LR_ASSERT_NOW(a_csr_taken, clock, reset, csr_valid, csr_ready, "register write refused")

endmodule

bind line_rasterizer_top lr_checker #(.COORD_BITS(COORD_BITS)) u_lr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_pixel_x    (rsp_pixel_x),
   .rsp_pixel_y    (rsp_pixel_y),
   .rsp_inside_res (rsp_inside_res),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready)
);

@@ tb/tb_line_rasterizer_top.sv @@
// Self-checking testbench for line_rasterizer_top: Bresenham line loads and pixel ticks.
// Predicts every pixel, clip flag and last flag, and checks the rsp_ queue field by field.
// Depends on lr_pkg and line_rasterizer_top.
`timescale 1ns / 1ps

module tb_line_rasterizer_top;
   import lr_pkg::*;

   localparam int CB           = LR_COORD_BITS;
   localparam int CMIN         = -(1 << (CB - 1));
   localparam int CMAX         = (1 << (CB - 1)) - 1;
   localparam int SETTLE       = 4;     // margin for a transfer to show on rsp_
   localparam int HOLD_CYCLES  = 300;   // long result back-pressure stretch
   localparam int PHASE_ITEMS  = 170;   // useful items per random phase

   typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_HEAVY} idle_mode_type;

   typedef struct {
      logic               op;
      logic signed [CB-1:0] x_start;
      logic signed [CB-1:0] y_start;
      logic signed [CB-1:0] x_end;
      logic signed [CB-1:0] y_end;
   } raster_req_type;

   typedef struct {
      logic signed [CB-1:0] px;
      logic signed [CB-1:0] py;
      logic                 inside_res;
      logic                 last;
   } pixel_type;

   // ---------------------------------------------------------------------
   // Clock, reset and block ports
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_push    = 1'b0;
   logic                  req_full;
   logic                  req_op      = OP_LOAD;
   logic signed [CB-1:0]  req_x_start = '0;
   logic signed [CB-1:0]  req_y_start = '0;
   logic signed [CB-1:0]  req_x_end   = '0;
   logic signed [CB-1:0]  req_y_end   = '0;

   logic                  rsp_empty;
   logic                  rsp_pop     = 1'b0;
   logic signed [CB-1:0]  rsp_pixel_x;
   logic signed [CB-1:0]  rsp_pixel_y;
   logic                  rsp_inside_res;
   logic                  rsp_last;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index = CSR_MAP_WIDTH;
   logic [DIM_BITS-1:0]       csr_data  = '0;

   always #5 clock = ~clock;

   line_rasterizer_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_op         (req_op),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_inside_res (rsp_inside_res),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // ---------------------------------------------------------------------
   // Shared testbench state
   // ---------------------------------------------------------------------
   raster_req_type pending[$];  // items waiting for the driver
   pixel_type      pixel_q[$];  // predicted pixels, oldest first
   raster_req_type cur_req;     // item currently offered on req_

   int items_queued = 0;        // items handed to the driver
   int items_sent   = 0;        // items that completed a transfer
   int useful       = 0;        // loads taken while idle plus ticks while busy
   int gen_rem      = 0;        // pixels still owed to the generator's current line
   int err_count    = 0;

   idle_mode_type send_mode = IDLE_NONE;
   idle_mode_type recv_mode = IDLE_NONE;
   int send_wait = 0;
   int recv_wait = 0;
   int hold_asks = 0;           // bumped by the stimulus to request a long hold-off
   int hold_seen = 0;
   int hold_left = 0;

   // predictor's copy of the map size and line engine
   logic [DIM_BITS-1:0] map_w = MAP_WIDTH_RESET;
   logic [DIM_BITS-1:0] map_h = MAP_HEIGHT_RESET;
   int   ln_major, ln_minor, ln_end;
   int   ln_decision, ln_inc_straight, ln_inc_diag;
   logic ln_minor_down = 1'b0;
   logic ln_steep      = 1'b0;
   logic ln_busy       = 1'b0;

   function automatic int iabs(input int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < CMIN) return CMIN;
      if (v > CMAX) return CMAX;
      return v;
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(0, (1 << CB) - 1)) + CMIN;
   endfunction

   function automatic int draw_wait(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:   return 0;
         IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 10)) : 0;
         default:     return int'($urandom_range(0, 10));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      err_count++;
   endtask

   // ---------------------------------------------------------------------
   // Pixel predictor: advance the line engine by one accepted item
   // ---------------------------------------------------------------------
   function automatic void raster_apply(input raster_req_type r);
      int xa, ya, xb, yb, ma, na, mb, nb, dmaj, dmin, px, py, t;
      pixel_type pix;
      if (r.op == OP_LOAD) begin
         // a load during a line is dropped, the line goes on
         if (ln_busy) return;
         xa = r.x_start;
         ya = r.y_start;
         xb = r.x_end;
         yb = r.y_end;
         ln_steep = iabs(yb - ya) > iabs(xb - xa);
         if (ln_steep) begin
            ma = ya; na = xa; mb = yb; nb = xb;
         end else begin
            ma = xa; na = ya; mb = xb; nb = yb;
         end
         // walk from the lower major end; a tie keeps the first endpoint
         if (ma > mb) begin
            t = ma; ma = mb; mb = t;
            t = na; na = nb; nb = t;
         end
         dmaj = mb - ma;
         dmin = nb - na;
         ln_minor_down   = dmin < 0;
         dmin            = iabs(dmin);
         ln_major        = ma;
         ln_minor        = na;
         ln_end          = mb;
         ln_inc_straight = 2 * dmin;
         ln_inc_diag     = 2 * dmin - 2 * dmaj;
         ln_decision     = 2 * dmin - dmaj;
         ln_busy         = 1'b1;
      end else if (ln_busy) begin
         px = ln_steep ? ln_minor : ln_major;
         py = ln_steep ? ln_major : ln_minor;
         pix.px         = px[CB-1:0];
         pix.py         = py[CB-1:0];
         pix.inside_res = px >= 0 && py >= 0 && px < int'(map_w) && py < int'(map_h);
         pix.last       = ln_major >= ln_end;
         pixel_q.push_back(pix);
         if (pix.last) begin
            ln_busy = 1'b0;
         end else begin
            if (ln_decision <= 0) begin
               ln_decision += ln_inc_straight;
            end else begin
               ln_decision += ln_inc_diag;
               ln_minor    += ln_minor_down ? -1 : 1;
            end
            ln_major += 1;
         end
      end
      // a tick while idle is dropped
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: offer pending items, hold each until its transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_push  <= 1'b0;
         send_wait = 0;
      end else if (!req_push || !req_full) begin
         // the item on req_ (if any) transferred at this edge: predict it
         if (req_push) begin
            raster_apply(cur_req);
            items_sent++;
         end
         if (send_wait > 0) begin
            send_wait--;
            req_push <= 1'b0;
         end else if (pending.size() != 0) begin
            cur_req     = pending.pop_front();
            req_push    <= 1'b1;
            req_op      <= cur_req.op;
            req_x_start <= cur_req.x_start;
            req_y_start <= cur_req.y_start;
            req_x_end   <= cur_req.x_end;
            req_y_end   <= cur_req.y_end;
            send_wait   = draw_wait(send_mode);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: check each popped pixel against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      pixel_type want;
      if (reset) begin
         rsp_pop   <= 1'b0;
         recv_wait = 0;
         hold_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pixel_q.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel (%0d,%0d)",
                                         rsp_pixel_x, rsp_pixel_y));
            end else begin
               want = pixel_q.pop_front();
               if (rsp_pixel_x !== want.px)
                  report_mismatch($sformatf("pixel_x %0d, predicted %0d",
                                            rsp_pixel_x, want.px));
               if (rsp_pixel_y !== want.py)
                  report_mismatch($sformatf("pixel_y %0d, predicted %0d",
                                            rsp_pixel_y, want.py));
               if (rsp_inside_res !== want.inside_res)
                  report_mismatch($sformatf("inside_res %0b at (%0d,%0d), predicted %0b",
                                            rsp_inside_res, want.px, want.py,
                                            want.inside_res));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b at (%0d,%0d), predicted %0b",
                                            rsp_last, want.px, want.py, want.last));
            end
            recv_wait = draw_wait(recv_mode);
         end
         // start a long hold-off when the stimulus asks for one
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // Queue one item and track the line length, so that useful items can be counted.
   function automatic void queue_item(input logic op, input int xs, ys, xe, ye);
      raster_req_type r;
      r.op      = op;
      r.x_start = xs[CB-1:0];
      r.y_start = ys[CB-1:0];
      r.x_end   = xe[CB-1:0];
      r.y_end   = ye[CB-1:0];
      pending.push_back(r);
      items_queued++;
      if (op == OP_LOAD && gen_rem == 0) begin
         gen_rem = ((iabs(xe - xs) > iabs(ye - ys)) ? iabs(xe - xs) : iabs(ye - ys)) + 1;
         useful++;
      end else if (op == OP_TICK && gen_rem > 0) begin
         gen_rem--;
         useful++;
      end
   endfunction

   // Ticks carry random endpoint fields, which the block must ignore.
   function automatic void queue_ticks(input int n);
      repeat (n) queue_item(OP_TICK, rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endfunction

   // Mostly short lines, some medium ones.
   function automatic void queue_random_line();
      int pick, span, ax, ay, ex, ey;
      pick = $urandom_range(0, 99);
      span = (pick < 12) ? 256 : 24;
      if (pick % 2) begin
         ax = rand_coord();
         ay = rand_coord();
      end else begin
         // anchor around the map so that both sides of every clip edge are hit
         ax = clamp_coord(int'($urandom_range(0, map_w + 40)) - 20);
         ay = clamp_coord(int'($urandom_range(0, map_h + 40)) - 20);
      end
      ex = clamp_coord(ax + int'($urandom_range(0, 2 * span)) - span);
      ey = clamp_coord(ay + int'($urandom_range(0, 2 * span)) - span);
      queue_item(OP_LOAD, ax, ay, ex, ey);
   endfunction

   // Whole lines with random content, plus idle ticks and loads dropped mid-line.
   function automatic void queue_random(input int target);
      int goal;
      goal = useful + target;
      while (useful < goal) begin
         if (gen_rem == 0) begin
            if ($urandom_range(0, 99) < 85) queue_random_line();
            else queue_ticks(1);
         end else if ($urandom_range(0, 99) < 93) begin
            queue_ticks(1);
         end else begin
            queue_item(OP_LOAD, rand_coord(), rand_coord(), rand_coord(), rand_coord());
         end
      end
   endfunction

   // Finish the open line, then hold until every transfer is done and every pixel is back.
   task automatic finish_phase();
      queue_ticks(gen_rem);
      @(posedge clock);
      while (items_sent != items_queued || pixel_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [DIM_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MAP_WIDTH) map_w = val;
      else map_h = val;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [DIM_BITS-1:0] w, h;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset map size, no idling on either side
      queue_ticks(1);                                // tick with no line loaded
      queue_item(OP_LOAD, 5, 5, 5, 5);               // equal endpoints: one pixel
      queue_ticks(1);
      queue_item(OP_LOAD, -2046, -2047, -2048, -2048); // lowest corner, ends swapped
      queue_ticks(3);
      queue_item(OP_LOAD, 2045, 2047, 2047, 2045);   // highest corner, minor going down
      queue_ticks(3);
      queue_item(OP_LOAD, 3, -1, 2, 1);              // steep, minor going down
      queue_ticks(1);
      queue_item(OP_LOAD, 0, 0, 100, 100);           // load during a line: dropped
      queue_ticks(2);
      queue_item(OP_LOAD, 639, 0, 640, -1);          // leaves the map across x and y
      queue_ticks(2);
      queue_item(OP_LOAD, 0, 639, -1, 640);          // leaves the map across y and x
      queue_ticks(2);
      queue_ticks(1);
      finish_phase();

      // Back-pressure: stall results for a long stretch while the sender keeps offering
      send_mode = IDLE_NONE;
      recv_mode = IDLE_SPARSE;
      hold_asks++;
      queue_item(OP_LOAD, 0, 0, 150, 37);
      queue_ticks(151);
      queue_item(OP_LOAD, 5, 600, -20, 700);
      finish_phase();

      // Random phases, each with its own map size and one of three idling mixes
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       begin w = 11'd1;    h = 11'd1;    end
            1:       begin w = 11'd2047; h = 11'd2047; end
            3:       begin w = 11'd2047; h = 11'd1;    end
            4:       begin w = 11'd1;    h = 11'd2047; end
            default: begin
               w = DIM_BITS'($urandom_range(1, 2047));
               h = DIM_BITS'($urandom_range(1, 2047));
            end
         endcase
         write_csr(CSR_MAP_WIDTH, w);
         write_csr(CSR_MAP_HEIGHT, h);
         send_mode = idle_mode_type'(p % 3);
         recv_mode = idle_mode_type'((p + 1) % 3);
         queue_random(PHASE_ITEMS);
         finish_phase();
      end

      repeat (2 * SETTLE) @(posedge clock);
      if (pixel_q.size() != 0)
         report_mismatch($sformatf("%0d predicted pixels never came", pixel_q.size()));
      if (err_count == 0) begin
         $display("tb_line_rasterizer_top: PASS");
      end else begin
         $display("tb_line_rasterizer_top: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #50_000_000;
      $display("tb_line_rasterizer_top: FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lr_pkg.sv
hw/rtl/lr_front.sv
hw/rtl/lr_back.sv
hw/rtl/lr_rsp_queue.sv
hw/rtl/line_rasterizer_top.sv
hw/rtl/lr_checker.sv
tb/tb_line_rasterizer_top.sv
